>>> rtl/core/rvuc_pkg.sv
// Package: shared types and constants of the raw video unit converter.
`timescale 1ns / 1ps
package rvuc_pkg;

    localparam int AMOUNT_W = 64;
    localparam int UNIT_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam int VALUE_WIDTH_DEF = 64;
    localparam int IN_TDATA_W  = 72;
    localparam int OUT_TDATA_W = 72;

    localparam logic [UNIT_W-1:0] UNIT_FRAMES = 2'd0;
    localparam logic [UNIT_W-1:0] UNIT_BYTES  = 2'd1;
    localparam logic [UNIT_W-1:0] UNIT_TIME   = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_SIZE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_NUM   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RATE_DEN   = 2'd2;

    localparam logic [29:0] TICKS_PER_SECOND = 30'd1000000000;

    typedef struct packed {
        logic valid;
        logic ok;
        logic sat;
    } div_ctl_t;

endpackage

>>> rtl/core/raw_video_unit_convert_core.sv
// Top level: pipelined raw video frames / bytes / nanoseconds converter.
//
//  channel   dir  handshake               payload
//  s_axis    in   s_tvalid / s_tready     s_tdata: source_unit, target_unit, source_amount
//  m_axis    out  m_tvalid / m_tready     m_tdata: converted_amount, success
//  cfg       in   cfg_valid / cfg_ready   cfg_index, cfg_data
//
// One transfer per cycle while m_axis is not stalled; stages: select, partial products,
// sum, 64 divide steps, output. The 64-step restoring divider sets the depth.
// Reset clears all valid bits and loads the register reset values.
// A stall on m_axis freezes the whole pipeline; nothing is lost or repeated.
`timescale 1ns / 1ps
module raw_video_unit_convert_core
#(
    parameter int VALUE_WIDTH = rvuc_pkg::VALUE_WIDTH_DEF
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [1:0] source_unit, [3:2] target_unit, [67:4] source_amount
    input  logic [rvuc_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [63:0] converted_amount, [64] success
    output logic [rvuc_pkg::OUT_TDATA_W-1:0]  m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [rvuc_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [rvuc_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int W = rvuc_pkg::AMOUNT_W;
    localparam int STEPS = W;
    localparam logic [W-1:0] MASK = {W{1'b1}} >> (W - VALUE_WIDTH);

    logic adv;

    // configuration; derived products are updated together with their sources
    logic [31:0]  size_reg;
    logic [30:0]  fn_reg;
    logic [30:0]  fd_reg;
    logic [W-1:0] fdt_reg;
    logic [W-1:0] fnsize_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg   <= '0;
            fn_reg     <= '0;
            fd_reg     <= 31'd1;
            fdt_reg    <= {34'd0, rvuc_pkg::TICKS_PER_SECOND};
            fnsize_reg <= '0;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rvuc_pkg::CFG_FRAME_SIZE:
                begin
                    size_reg   <= cfg_data;
                    fnsize_reg <= {33'd0, fn_reg} * {32'd0, cfg_data};
                end
                rvuc_pkg::CFG_RATE_NUM:
                begin
                    fn_reg     <= cfg_data[30:0];
                    fnsize_reg <= {33'd0, cfg_data[30:0]} * {32'd0, size_reg};
                end
                rvuc_pkg::CFG_RATE_DEN:
                begin
                    fd_reg  <= cfg_data[30:0];
                    fdt_reg <= {33'd0, cfg_data[30:0]}
                               * {34'd0, rvuc_pkg::TICKS_PER_SECOND};
                end
                default: ;
            endcase
        end
    end

    // stage A: select factor and divisor
    logic [1:0]   src, dst;
    logic [W-1:0] v;
    logic [W-1:0] m_next, d_next;
    logic         ok_next, wrap_next;
    logic         size_nz, fn_nz, fd_nz;

    logic         a_valid_reg;
    logic [W-1:0] a_v_reg, a_m_reg, a_d_reg;
    logic         a_ok_reg, a_wrap_reg;

    always_comb
    begin
        src     = s_tdata[1:0];
        dst     = s_tdata[3:2];
        v       = s_tdata[67:4] & MASK;
        size_nz = size_reg != '0;
        fn_nz   = fn_reg != '0;
        fd_nz   = fd_reg != '0;
        m_next    = '0;
        d_next    = W'(1);
        ok_next   = 1'b1;
        wrap_next = 1'b0;
        if (src == dst || v == '0 || v == MASK)
        begin
            m_next = W'(1);
        end
        else if (src == rvuc_pkg::UNIT_BYTES && dst == rvuc_pkg::UNIT_FRAMES && size_nz)
        begin
            m_next = W'(1);
            d_next = W'(size_reg);
        end
        else if (src == rvuc_pkg::UNIT_FRAMES && dst == rvuc_pkg::UNIT_BYTES && size_nz)
        begin
            m_next    = W'(size_reg);
            wrap_next = 1'b1;
        end
        else if (src == rvuc_pkg::UNIT_FRAMES && dst == rvuc_pkg::UNIT_TIME && fn_nz)
        begin
            m_next = fdt_reg;
            d_next = W'(fn_reg);
        end
        else if (src == rvuc_pkg::UNIT_TIME && dst == rvuc_pkg::UNIT_FRAMES && fd_nz)
        begin
            m_next = W'(fn_reg);
            d_next = fdt_reg;
        end
        else if (src == rvuc_pkg::UNIT_TIME && dst == rvuc_pkg::UNIT_BYTES
                 && fd_nz && size_nz)
        begin
            m_next = fnsize_reg;
            d_next = fdt_reg;
        end
        else if (src == rvuc_pkg::UNIT_BYTES && dst == rvuc_pkg::UNIT_TIME
                 && fn_nz && size_nz)
        begin
            m_next = fdt_reg;
            d_next = fnsize_reg;
        end
        else
        begin
            ok_next = 1'b0;
        end
    end

    // stage B: partial products
    logic         b_valid_reg;
    logic [63:0]  b_ll_reg, b_lh_reg, b_hl_reg, b_hh_reg;
    logic [W-1:0] b_d_reg;
    logic         b_ok_reg, b_wrap_reg;

    // stage C: sum and overflow check
    logic [33:0]  mid;
    logic [W-1:0] hi_next, lo_next;
    rvuc_pkg::div_ctl_t c_ctl_reg;
    logic [W-1:0] c_hi_reg, c_lo_reg, c_d_reg;

    always_comb
    begin
        mid     = 34'(b_ll_reg[63:32]) + 34'(b_lh_reg[31:0]) + 34'(b_hl_reg[31:0]);
        lo_next = {mid[31:0], b_ll_reg[31:0]};
        hi_next = b_hh_reg + W'(b_lh_reg[63:32]) + W'(b_hl_reg[63:32]) + W'(mid[33:32]);
        if (b_wrap_reg)
        begin
            hi_next = '0;
            lo_next = lo_next & MASK;
        end
    end

    // divider chain
    rvuc_pkg::div_ctl_t ctl_w [0:STEPS];
    logic [W-1:0]       rem_w [0:STEPS];
    logic [W-1:0]       lq_w  [0:STEPS];
    logic [W-1:0]       den_w [0:STEPS];

    assign ctl_w[0] = c_ctl_reg;
    assign rem_w[0] = c_hi_reg;
    assign lq_w[0]  = c_lo_reg;
    assign den_w[0] = c_d_reg;

    for (genvar i = 0; i < STEPS; i++)
    begin : g_div
        rvuc_div_stage u_step
        (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (adv),
            .ctl_in  (ctl_w[i]),
            .rem_in  (rem_w[i]),
            .lq_in   (lq_w[i]),
            .den_in  (den_w[i]),
            .ctl_out (ctl_w[i+1]),
            .rem_out (rem_w[i+1]),
            .lq_out  (lq_w[i+1]),
            .den_out (den_w[i+1])
        );
    end

    // output stage
    logic         out_valid_reg;
    logic [W-1:0] out_amount_reg, r_next;
    logic         out_ok_reg;

    always_comb
    begin
        if (ctl_w[STEPS].sat || lq_w[STEPS] > MASK)
            r_next = MASK;
        else
            r_next = lq_w[STEPS];
        if (r_next[VALUE_WIDTH-1])
            r_next = r_next | ~MASK;
    end

    assign adv      = !out_valid_reg || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            c_ctl_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            a_valid_reg     <= s_tvalid;
            b_valid_reg     <= a_valid_reg;
            c_ctl_reg.valid <= b_valid_reg;
            c_ctl_reg.ok    <= b_ok_reg;
            c_ctl_reg.sat   <= hi_next >= b_d_reg;
            out_valid_reg   <= ctl_w[STEPS].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            a_v_reg    <= v;
            a_m_reg    <= m_next;
            a_d_reg    <= d_next;
            a_ok_reg   <= ok_next;
            a_wrap_reg <= wrap_next;

            b_ll_reg   <= a_v_reg[31:0]  * a_m_reg[31:0];
            b_lh_reg   <= a_v_reg[31:0]  * a_m_reg[63:32];
            b_hl_reg   <= a_v_reg[63:32] * a_m_reg[31:0];
            b_hh_reg   <= a_v_reg[63:32] * a_m_reg[63:32];
            b_d_reg    <= a_d_reg;
            b_ok_reg   <= a_ok_reg;
            b_wrap_reg <= a_wrap_reg;

            c_hi_reg   <= hi_next;
            c_lo_reg   <= lo_next;
            c_d_reg    <= b_d_reg;

            out_amount_reg <= ctl_w[STEPS].ok ? r_next : '0;
            out_ok_reg     <= ctl_w[STEPS].ok;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_ok_reg, out_amount_reg};

endmodule

>>> rtl/core/rvuc_div_stage.sv
// One restoring divide step of the long-division pipeline.
`timescale 1ns / 1ps
module rvuc_div_stage
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  rvuc_pkg::div_ctl_t            ctl_in,
    input  logic [rvuc_pkg::AMOUNT_W-1:0] rem_in,
    input  logic [rvuc_pkg::AMOUNT_W-1:0] lq_in,
    input  logic [rvuc_pkg::AMOUNT_W-1:0] den_in,
    output rvuc_pkg::div_ctl_t            ctl_out,
    output logic [rvuc_pkg::AMOUNT_W-1:0] rem_out,
    output logic [rvuc_pkg::AMOUNT_W-1:0] lq_out,
    output logic [rvuc_pkg::AMOUNT_W-1:0] den_out
);

    localparam int W = rvuc_pkg::AMOUNT_W;

    rvuc_pkg::div_ctl_t ctl_reg;
    logic [W-1:0]       rem_reg, rem_next;
    logic [W-1:0]       lq_reg, lq_next;
    logic [W-1:0]       den_reg;
    logic [W:0]         shifted;
    logic               take;

    always_comb
    begin
        shifted  = {rem_in, lq_in[W-1]};
        take     = shifted >= {1'b0, den_in};
        rem_next = take ? W'(shifted - {1'b0, den_in}) : shifted[W-1:0];
        lq_next  = {lq_in[W-2:0], take};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else if (en)
        begin
            ctl_reg <= ctl_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg <= rem_next;
            lq_reg  <= lq_next;
            den_reg <= den_in;
        end
    end

    assign ctl_out = ctl_reg;
    assign rem_out = rem_reg;
    assign lq_out  = lq_reg;
    assign den_out = den_reg;

endmodule
